// ===== sv/usd_pkg.sv =====
package usd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 31;
    localparam int LEN_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] CONT_MASK   = 8'h3F;
    localparam logic [BYTE_W-1:0] CONT_TAG    = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_SELECT = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MIN   = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MIN   = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD5_MIN   = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD6_MIN   = 8'hFC;

    typedef logic [LEN_W-1:0] t_len;

    localparam t_len LEN_CONT = 3'd0;
    localparam t_len LEN_1    = 3'd1;
    localparam t_len LEN_2    = 3'd2;
    localparam t_len LEN_3    = 3'd3;
    localparam t_len LEN_4    = 3'd4;
    localparam t_len LEN_5    = 3'd5;
    localparam t_len LEN_6    = 3'd6;

    typedef struct packed {
        t_len              len;
        logic [BYTE_W-1:0] bits;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== sv/utf8_stream_decoder_top.sv =====
// channel | dir | handshake          | beat payload
// --------+-----+--------------------+--------------------------------------
// input   | in  | i_valid / o_stall  | i_in_byte[7:0]
// result  | out | o_valid / i_stall  | o_code_point[30:0] o_seq_len[2:0] o_error
//
// Accepts one byte beat per cycle while o_stall is low; a result passes the queue, then the result register.
// The decode update in the back end sets the rate of one beat per cycle while the result register is not held.
// Synchronous active-low reset empties the queue and returns the decoder to idle.
// o_stall rises only when the queue between front and back is full.
// A held result register stops the back end; the queue absorbs beats meanwhile.
module utf8_stream_decoder_top #(
    parameter int QUEUE_DEPTH = usd_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [usd_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [usd_pkg::CP_W-1:0]    o_code_point,
    output logic [usd_pkg::LEN_W-1:0]   o_seq_len,
    output logic                        o_error
);
    import usd_pkg::*;

    t_entry  push_entry;
    t_entry  pop_entry;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    usd_front u_front (
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_q_stat  (q_stat),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    usd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (pop_entry),
        .o_q_stat (q_stat)
    );

    usd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (pop_entry),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_code_point (o_code_point),
        .o_seq_len    (o_seq_len),
        .o_error      (o_error)
    );

endmodule

// ===== sv/usd_front.sv =====
module usd_front (
    input  logic                        i_valid,
    input  logic [usd_pkg::BYTE_W-1:0]  i_in_byte,
    input  usd_pkg::t_q_stat            i_q_stat,
    output logic                        o_stall,
    output logic                        o_push,
    output usd_pkg::t_entry             o_entry
);
    import usd_pkg::*;

    t_len len;

    always_comb begin
        priority if (i_in_byte < CONT_TAG) begin
            len = LEN_1;
        end else if (i_in_byte < CONT_SELECT) begin
            len = LEN_CONT;
        end else if (i_in_byte < LEAD3_MIN) begin
            len = LEN_2;
        end else if (i_in_byte < LEAD4_MIN) begin
            len = LEN_3;
        end else if (i_in_byte < LEAD5_MIN) begin
            len = LEN_4;
        end else if (i_in_byte < LEAD6_MIN) begin
            len = LEN_5;
        end else begin
            len = LEN_6;
        end
    end

    always_comb begin
        o_entry.len = len;
        unique case (len)
            LEN_CONT: o_entry.bits = i_in_byte & CONT_MASK;
            LEN_1:    o_entry.bits = i_in_byte;
            LEN_2:    o_entry.bits = i_in_byte & 8'h1F;
            LEN_3:    o_entry.bits = i_in_byte & 8'h0F;
            LEN_4:    o_entry.bits = i_in_byte & 8'h07;
            LEN_5:    o_entry.bits = i_in_byte & 8'h03;
            default:  o_entry.bits = i_in_byte & 8'h01;
        endcase
    end

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

endmodule

// ===== sv/usd_queue.sv =====
module usd_queue #(
    parameter int DEPTH = usd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  usd_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output usd_pkg::t_entry  o_entry,
    output usd_pkg::t_q_stat o_q_stat
);
    import usd_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [IDX_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry        = r_mem[r_rd_ptr];
    assign o_q_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_q_stat.empty = (r_count == '0);

endmodule

// ===== sv/usd_back.sv =====
module usd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  usd_pkg::t_entry            i_entry,
    input  usd_pkg::t_q_stat           i_q_stat,
    output logic                       o_pop,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [usd_pkg::CP_W-1:0]   o_code_point,
    output logic [usd_pkg::LEN_W-1:0]  o_seq_len,
    output logic                       o_error
);
    import usd_pkg::*;

    t_len             r_left,    n_left;
    t_len             r_total,   n_total;
    logic [CP_W-1:0]  r_partial, n_partial;
    logic             r_valid,   n_valid;
    logic [CP_W-1:0]  r_cp,      n_cp;
    t_len             r_len,     n_len;
    logic             r_err,     n_err;
    logic [CP_W-1:0]  shifted;
    t_len             left_dec;

    assign o_pop    = !i_q_stat.empty && (!r_valid || !i_stall);
    assign shifted  = {r_partial[CP_W-7:0], i_entry.bits[5:0]};
    assign left_dec = r_left - 1'b1;

    always_comb begin
        n_left    = r_left;
        n_total   = r_total;
        n_partial = r_partial;
        n_valid   = r_valid && i_stall;
        n_cp      = r_cp;
        n_len     = r_len;
        n_err     = r_err;
        if (o_pop) begin
            if (r_left == '0) begin
                if (i_entry.len == LEN_CONT) begin
                    n_valid = 1'b1;
                    n_cp    = '0;
                    n_len   = '0;
                    n_err   = 1'b1;
                end else if (i_entry.len == LEN_1) begin
                    n_valid = 1'b1;
                    n_cp    = CP_W'(i_entry.bits);
                    n_len   = LEN_1;
                    n_err   = 1'b0;
                end else begin
                    n_partial = CP_W'(i_entry.bits);
                    n_total   = i_entry.len;
                    n_left    = i_entry.len - 1'b1;
                end
            end else if (i_entry.len != LEN_CONT) begin
                n_left    = '0;
                n_total   = '0;
                n_partial = '0;
                n_valid   = 1'b1;
                n_cp      = '0;
                n_len     = '0;
                n_err     = 1'b1;
            end else if (left_dec == '0) begin
                n_left    = '0;
                n_total   = '0;
                n_partial = '0;
                n_valid   = 1'b1;
                n_cp      = shifted;
                n_len     = r_total;
                n_err     = 1'b0;
            end else begin
                n_left    = left_dec;
                n_partial = shifted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_total   <= '0;
            r_partial <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_left    <= n_left;
            r_total   <= n_total;
            r_partial <= n_partial;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp  <= n_cp;
        r_len <= n_len;
        r_err <= n_err;
    end

    assign o_valid      = r_valid;
    assign o_code_point = r_cp;
    assign o_seq_len    = r_len;
    assign o_error      = r_err;

endmodule
